### rtl/core/tfpc_pkg.sv
// ----------------------------------------------------------------------------
// tfpc_pkg
// Shared constants, types and the CRC-8 byte step of the thermal frame checker.
// ----------------------------------------------------------------------------
package tfpc_pkg;

    localparam int          MaxFrameBytesDef = 35;
    localparam int          FrameLen8px      = 19;
    localparam int          FrameLen16px     = 35;
    localparam int          WordIdxW         = 5;
    localparam logic [7:0]  CrcPoly          = 8'h07;
    localparam logic [7:0]  PrefixByte0      = 8'h14;
    localparam logic [7:0]  PrefixByte1      = 8'h4C;
    localparam logic [7:0]  PrefixByte2      = 8'h15;

    // One received byte with its start marker.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_item;

    // One result item.
    typedef struct packed {
        logic signed [15:0]    word_value;
        logic [WordIdxW-1:0]   word_index;
        logic                  is_check;
        logic                  pec_ok;
        logic                  frame_last;
    } t_result;

    // CRC-8, MSB first, one byte per call.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CrcPoly;
            end else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

    localparam logic [7:0] PrefixCrc =
        crc8_feed(crc8_feed(crc8_feed(8'h00, PrefixByte0), PrefixByte1), PrefixByte2);

endpackage

### rtl/core/tfpc_in_stage.sv
// ----------------------------------------------------------------------------
// tfpc_in_stage
// Input register: holds one accepted byte until the frame logic consumes it.
// ----------------------------------------------------------------------------
module tfpc_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  tfpc_pkg::t_item i_item,
    input  logic            i_advance,
    output logic            o_in_ready,
    output logic            o_item_valid,
    output tfpc_pkg::t_item o_item
);
    import tfpc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;

    assign o_in_ready   = !r_valid || i_advance;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_item;
        end
    end

endmodule

### rtl/core/tfpc_frame_core.sv
// ----------------------------------------------------------------------------
// tfpc_frame_core
// Frame state: byte count, low byte of the open pair and running CRC, plus the
// model select register. Builds at most one result from each consumed byte.
// ----------------------------------------------------------------------------
module tfpc_frame_core #(
    parameter int MAX_FRAME_BYTES = tfpc_pkg::MaxFrameBytesDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_fire,
    input  tfpc_pkg::t_item   i_item,
    output logic              o_res_valid,
    output tfpc_pkg::t_result o_res
);
    import tfpc_pkg::*;

    localparam int CntW   = $clog2(MAX_FRAME_BYTES + 1);
    localparam int Len8   = (FrameLen8px  > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : FrameLen8px;
    localparam int Len16  = (FrameLen16px > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : FrameLen16px;
    localparam logic [CntW-1:0] Len8C  = CntW'(Len8);
    localparam logic [CntW-1:0] Len16C = CntW'(Len16);

    logic            r_model_sel;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    logic [7:0]      r_low;
    logic [7:0]      n_low;
    logic [7:0]      r_crc;
    logic [7:0]      n_crc;
    logic [CntW-1:0] len;
    logic [CntW-1:0] cnt_eff;
    logic [7:0]      crc_eff;

    always_comb begin
        len     = r_model_sel ? Len16C : Len8C;
        cnt_eff = i_item.frame_start ? '0 : r_cnt;
        crc_eff = i_item.frame_start ? PrefixCrc : r_crc;

        n_cnt = cnt_eff;
        n_low = r_low;
        n_crc = crc_eff;

        o_res_valid      = 1'b0;
        o_res.word_value = {r_low, r_low} & 16'h0000 | {i_item.rx_byte, r_low};
        o_res.word_index = WordIdxW'(cnt_eff >> 1);
        o_res.is_check   = 1'b0;
        o_res.pec_ok     = 1'b0;
        o_res.frame_last = 1'b0;

        if (cnt_eff < len) begin
            n_cnt = cnt_eff + 1'b1;
            if (cnt_eff == len - 1'b1) begin
                // Last byte of the frame carries the packet error code.
                o_res_valid      = 1'b1;
                o_res.word_value = {8'h00, i_item.rx_byte};
                o_res.word_index = WordIdxW'((len - 1'b1) >> 1);
                o_res.is_check   = 1'b1;
                o_res.pec_ok     = (crc_eff == i_item.rx_byte);
                o_res.frame_last = 1'b1;
            end else begin
                n_crc = crc8_feed(crc_eff, i_item.rx_byte);
                if (!cnt_eff[0]) begin
                    n_low = i_item.rx_byte;
                end else begin
                    o_res_valid = 1'b1;
                end
            end
        end
        o_res_valid = o_res_valid && i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_sel <= 1'b1;
            r_cnt       <= '0;
            r_low       <= '0;
            r_crc       <= PrefixCrc;
        end else begin
            if (i_cfg_we) begin
                r_model_sel <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_cnt <= n_cnt;
                r_low <= n_low;
                r_crc <= n_crc;
            end
        end
    end

endmodule

### rtl/core/tfpc_out_stage.sv
// ----------------------------------------------------------------------------
// tfpc_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module tfpc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  tfpc_pkg::t_result i_res,
    input  logic              i_out_ready,
    output logic              o_advance,
    output logic              o_out_valid,
    output tfpc_pkg::t_result o_res
);
    import tfpc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_advance   = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_comb begin
        n_valid = r_valid;
        if (o_advance) begin
            n_valid = i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

### rtl/core/thermal_frame_pec_checker.sv
// ----------------------------------------------------------------------------
// thermal_frame_pec_checker
// Joins sensor frame bytes into signed words and checks the CRC-8 packet
// error code at the end of each frame.
// ----------------------------------------------------------------------------
//  Channel | Handshake                 | Payload
//  --------+---------------------------+------------------------------------
//  in      | i_in_valid / o_in_ready   | i_rx_byte, i_frame_start
//  out     | o_out_valid / i_out_ready | o_word_value, o_word_index,
//          |                           | o_is_check, o_pec_ok, o_frame_last
//  cfg     | i_cfg_we                  | i_cfg_wdata (model select)
//
// One byte is accepted per cycle while the output is not stalled. A byte is
// registered in the input register, consumed by the frame logic, and its result
// (if any) is registered in the result register. Synchronous reset selects the
// 16-pixel model and restarts the frame. When the output is stalled, one byte
// waits in the input register and the input then deasserts ready.
// ----------------------------------------------------------------------------
module thermal_frame_pec_checker #(
    parameter int MAX_FRAME_BYTES = tfpc_pkg::MaxFrameBytesDef
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_rx_byte,
    input  logic                                i_frame_start,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [15:0]                  o_word_value,
    output logic [tfpc_pkg::WordIdxW-1:0]       o_word_index,
    output logic                                o_is_check,
    output logic                                o_pec_ok,
    output logic                                o_frame_last
);
    import tfpc_pkg::*;

    localparam int MaxWords = (MAX_FRAME_BYTES + 1) / 2;

    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    advance;
    logic    fire;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.rx_byte     = i_rx_byte;
    assign in_item.frame_start = i_frame_start;
    assign fire                = stage_valid && advance;

    tfpc_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_item       (in_item),
        .i_advance    (advance),
        .o_in_ready   (o_in_ready),
        .o_item_valid (stage_valid),
        .o_item       (stage_item)
    );

    tfpc_frame_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_frame_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (stage_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tfpc_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_res       (out_res)
    );

    assign o_word_value = out_res.word_value;
    assign o_word_index = out_res.word_index;
    assign o_is_check   = out_res.is_check;
    assign o_pec_ok     = out_res.pec_ok;
    assign o_frame_last = out_res.frame_last;

    // A word result never claims a PEC match.
    a_word_no_pec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_check) |-> (!o_pec_ok && !o_frame_last))
        else $error("word result carries check flags");

    // Word indexes stay inside the largest frame.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_word_index) < MaxWords))
        else $error("word index beyond frame");

    // A full input register behind a stalled output blocks new requests.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (stage_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while pipeline is blocked");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

### tb/sv/tb_thermal_frame_pec_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_thermal_frame_pec_checker
// Self-checking bench for the thermal frame checker. Byte requests are driven
// with random gaps on the input channel, and an internal frame tracker predicts
// every joined word and every PEC verdict. The tracker follows the frame
// counter, the held low byte, the running CRC-8 and the model select. Results
// are matched in order against the predictions. The bench covers output
// back-pressure, mid-frame model changes, truncated frames, stray bytes and
// corrupted PEC bytes.
// ----------------------------------------------------------------------------
module tb_thermal_frame_pec_checker;
    import tfpc_pkg::*;

    localparam int MaxFrameBytes = MaxFrameBytesDef;
    localparam int PipeSettle    = 4;     // settle time past the input and result registers, plus margin
    localparam int RandomItems   = 380;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_wdata   = 1'b0;
    logic                   i_in_valid    = 1'b0;
    logic [7:0]             i_rx_byte     = 8'h00;
    logic                   i_frame_start = 1'b0;
    logic                   i_out_ready   = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic signed [15:0]     o_word_value;
    logic [WordIdxW-1:0]    o_word_index;
    logic                   o_is_check;
    logic                   o_pec_ok;
    logic                   o_frame_last;

    // Frame tracker state.
    bit                     sel16;
    logic [5:0]             byte_pos;
    logic [7:0]             lo_hold;
    logic [7:0]             crc_acc;
    logic [7:0]             prefix_crc;

    t_result                pending_words[$];
    logic [7:0]             data_script[$];
    int                     err_cnt     = 0;
    int                     live_items  = 0;
    bit                     tx_idle_on  = 1'b1;
    bit                     rx_idle_on  = 1'b1;
    int                     rx_hold_req = 0;
    int                     rx_gap      = 0;

    thermal_frame_pec_checker #(
        .MAX_FRAME_BYTES(MaxFrameBytes)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_rx_byte    (i_rx_byte),
        .i_frame_start(i_frame_start),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_word_value (o_word_value),
        .o_word_index (o_word_index),
        .o_is_check   (o_is_check),
        .o_pec_ok     (o_pec_ok),
        .o_frame_last (o_frame_last)
    );

    always #1 i_clk = ~i_clk;

    // Bit-serial form of the CRC-8: feedback is the top bit xor the data bit.
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            r = {r[6:0], 1'b0} ^ (((r[7] ^ data[i]) != 1'b0) ? CrcPoly : 8'h00);
        end
        return r;
    endfunction

    function automatic int cur_frame_len();
        int len;
        len = sel16 ? FrameLen16px : FrameLen8px;
        if (len > MaxFrameBytes) begin
            len = MaxFrameBytes;
        end
        return len;
    endfunction

    // Advances the frame tracker by one accepted byte. Returns 0 when the byte
    // falls past the end of the frame and is dropped by the block.
    function automatic bit predict_frame_byte(input logic [7:0] b, input logic st);
        t_result word;
        int      flen;
        if (st) begin
            byte_pos = '0;
            crc_acc  = prefix_crc;
        end
        flen = cur_frame_len();
        if (byte_pos >= flen) begin
            return 1'b0;
        end
        if (byte_pos == flen - 1) begin
            word.word_value = {8'h00, b};
            word.word_index = WordIdxW'((flen - 1) / 2);
            word.is_check   = 1'b1;
            word.pec_ok     = (crc_acc == b);
            word.frame_last = 1'b1;
            pending_words.push_back(word);
        end else begin
            crc_acc = crc8_step(crc_acc, b);
            if (!byte_pos[0]) begin
                lo_hold = b;
            end else begin
                word.word_value = {b, lo_hold};
                word.word_index = WordIdxW'(byte_pos >> 1);
                word.is_check   = 1'b0;
                word.pec_ok     = 1'b0;
                word.frame_last = 1'b0;
                pending_words.push_back(word);
            end
        end
        byte_pos = byte_pos + 1'b1;
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_byte();
        if (data_script.size() != 0) begin
            return data_script.pop_front();
        end
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void cmp_field(input string fname, input int want_v, input int got_v);
        if (want_v != got_v) begin
            err_cnt++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, fname, want_v, got_v);
        end
    endfunction

    // The valid of a request stays high after acceptance so that a back-to-back
    // request needs no second assignment in the same time step.
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= st;
        do @(posedge i_clk); while (!o_in_ready);
        if (predict_frame_byte(b, st)) begin
            live_items++;
        end
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (PipeSettle) @(posedge i_clk);
    endtask

    task automatic write_model(input bit v);
        wait_results_done();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sel16 = v;
    endtask

    // Sends one frame. A positive cut stops it early; extra appends bytes past
    // the PEC. At byte pause_at the sender drains and, with flip, toggles the
    // model, after which the frame length of the new model applies.
    task automatic send_frame(input bit with_start, input int cut, input int extra,
                              input bit good_pec, input int pause_at, input bit flip);
        int         flen;
        int         lim;
        logic [7:0] crc_run;
        logic [7:0] b;
        flen    = cur_frame_len();
        lim     = (cut > 0) ? cut : flen + extra;
        crc_run = prefix_crc;
        for (int k = 0; k < lim; k++) begin
            if (k == pause_at && k != 0) begin
                if (flip) begin
                    write_model(!sel16);
                    flen = cur_frame_len();
                    lim  = ((flen > k) ? flen : k) + extra;
                end else begin
                    wait_results_done();
                end
            end
            b = pick_byte();
            if (k == flen - 1) begin
                b = good_pec ? crc_run : crc_run ^ (8'h01 << $urandom_range(0, 7));
            end else if (k < flen - 1) begin
                crc_run = crc8_step(crc_run, b);
            end
            send_byte(b, with_start && k == 0);
        end
    endtask

    // Bytes with no start after reset, word extremes, then a switch to the
    // 8-pixel model partway through and two trailing bytes that are dropped.
    task automatic test_start_free_frame();
        data_script = {8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00};
        send_frame(1'b0, 0, 2, 1'b1, 4, 1'b1);
        wait_results_done();
    endtask

    // The receiver holds off long enough for the input to fill and stall.
    task automatic test_output_stall();
        write_model(1'b1);
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        rx_hold_req = 300;
        send_frame(1'b1, 0, 0, 1'b1, -1, 1'b0);
        send_frame(1'b1, 0, 0, 1'b1, -1, 1'b0);
        wait_results_done();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // The sender pauses mid-frame until every word has come out; bad PEC.
    task automatic test_sender_pause();
        send_frame(1'b1, 0, 1, 1'b0, 17, 1'b0);
        wait_results_done();
    endtask

    task automatic test_random_frames(input int n_items);
        int target;
        int flen;
        target = live_items + n_items;
        while (live_items < target) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 5) == 0) begin
                write_model($urandom_range(0, 1));
            end
            flen = cur_frame_len();
            case ($urandom_range(0, 19))
                14, 15: send_frame(1'b1, $urandom_range(1, flen - 1), 0, 1'b1, -1, 1'b0);
                16, 17: send_frame(1'b1, 0, $urandom_range(1, 3), $urandom_range(0, 5) != 0,
                                   $urandom_range(1, flen - 1), 1'b1);
                18, 19: begin
                    repeat ($urandom_range(1, 6)) begin
                        send_byte(pick_byte(), $urandom_range(0, 3) == 0);
                    end
                end
                default: send_frame(1'b1, 0, $urandom_range(0, 3), $urandom_range(0, 6) != 0,
                                    -1, 1'b0);
            endcase
        end
        wait_results_done();
    endtask

    // Receiver: draws a stall length per result; a hold request overrides it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                rx_gap = rx_idle_on ? $urandom_range(0, 15) : 0;
            end
            if (rx_hold_req != 0) begin
                rx_gap      = rx_hold_req;
                rx_hold_req = 0;
            end
            if (rx_gap != 0) begin
                i_out_ready <= 1'b0;
                rx_gap--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_words.size() == 0) begin
                err_cnt++;
                $display("%0t ns: unexpected result, expected none, got value %0d index %0d",
                         $time, o_word_value, o_word_index);
            end else begin
                want = pending_words.pop_front();
                cmp_field("word_value", want.word_value, o_word_value);
                cmp_field("word_index", want.word_index, o_word_index);
                cmp_field("is_check", want.is_check, o_is_check);
                cmp_field("pec_ok", want.pec_ok, o_pec_ok);
                cmp_field("frame_last", want.frame_last, o_frame_last);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        prefix_crc = crc8_step(crc8_step(crc8_step(8'h00, PrefixByte0), PrefixByte1),
                               PrefixByte2);
        sel16    = 1'b1;
        byte_pos = '0;
        lo_hold  = 8'h00;
        crc_acc  = prefix_crc;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_start_free_frame();
        test_output_stall();
        test_sender_pause();
        test_random_frames(RandomItems);

        repeat (10) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/tfpc_pkg.sv
rtl/core/tfpc_in_stage.sv
rtl/core/tfpc_frame_core.sv
rtl/core/tfpc_out_stage.sv
rtl/core/thermal_frame_pec_checker.sv
tb/sv/tb_thermal_frame_pec_checker.sv
